@@ rtl/core/dnt_pkg.sv @@
package dnt_pkg;

  localparam int TABLE_SIZE_DEF = 4;
  localparam logic [7:0] DEFAULT_DEVICE_RESET = 8'd8;

  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_REMOVE  = 3'd1,
    FN_LOOKUP  = 3'd2,
    FN_CLEAR   = 3'd3,
    FN_RESTORE = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic       failed;
    logic       found;
    logic [6:0] index;
  } result_t;

endpackage

@@ rtl/core/dnt_if.sv @@
interface dnt_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] device;

  modport source (output valid, output func, output device, input ready);
  modport sink   (input valid, input func, input device, output ready);
endinterface

interface dnt_rsp_if;
  logic       valid;
  logic       ready;
  logic       failed;
  logic       found;
  logic [6:0] index;

  modport source (output valid, output failed, output found, output index, input ready);
  modport sink   (input valid, input failed, input found, input index, output ready);
endinterface

@@ rtl/core/dnt_ctrl.sv @@
module dnt_ctrl #(
  parameter int TABLE_SIZE = dnt_pkg::TABLE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic [2:0]       cmd_func,
  input  logic [7:0]       cmd_device,
  output logic             cmd_ready,
  input  logic [7:0]       default_device,
  output logic             res_valid,
  input  logic             res_take,
  output dnt_pkg::result_t res
);

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  dnt_pkg::state_t  state;
  dnt_pkg::func_t   func_q;
  dnt_pkg::func_t   func_in;
  logic [7:0]       key;
  logic [7:0]       wval;
  logic [IDX_W-1:0] idx;
  logic [7:0]       slots [TABLE_SIZE];
  logic             hit;
  logic             load;

  assign func_in   = dnt_pkg::func_t'(cmd_func);
  assign cmd_ready = (state == dnt_pkg::ST_IDLE);
  assign res_valid = (state == dnt_pkg::ST_DONE);
  assign load      = cmd_valid && cmd_ready;
  assign hit       = (slots[idx] == key);

  // shared compare unit walks one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dnt_pkg::ST_IDLE;
    end else begin
      unique case (state)
        dnt_pkg::ST_IDLE: begin
          if (load) begin
            if ((func_in == dnt_pkg::FN_ADD) || (func_in == dnt_pkg::FN_REMOVE) ||
                (func_in == dnt_pkg::FN_RESTORE) ||
                ((func_in == dnt_pkg::FN_LOOKUP) && !cmd_device[7])) begin
              state <= dnt_pkg::ST_SCAN;
            end else begin
              state <= dnt_pkg::ST_DONE;
            end
          end
        end
        dnt_pkg::ST_SCAN: begin
          if (hit || (idx == LAST_IDX)) begin
            state <= dnt_pkg::ST_DONE;
          end
        end
        dnt_pkg::ST_DONE: begin
          if (res_take) begin
            state <= dnt_pkg::ST_IDLE;
          end
        end
        default: state <= dnt_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == dnt_pkg::ST_IDLE) begin
      if (load) begin
        func_q <= func_in;
        idx    <= '0;
        case (func_in)
          dnt_pkg::FN_ADD: begin
            key  <= 8'd0;
            wval <= cmd_device;
            res  <= '0;
          end
          dnt_pkg::FN_RESTORE: begin
            key  <= 8'd0;
            wval <= default_device;
            res  <= '0;
          end
          dnt_pkg::FN_REMOVE: begin
            key  <= cmd_device;
            wval <= 8'd0;
            res  <= '0;
          end
          dnt_pkg::FN_LOOKUP: begin
            key  <= cmd_device;
            wval <= 8'd0;
            if (cmd_device[7]) begin
              res <= '{failed: 1'b0, found: 1'b1, index: 7'(8'hFF - cmd_device)};
            end else begin
              res <= '0;
            end
          end
          default: begin
            key  <= 8'd0;
            wval <= 8'd0;
            res  <= '0;
          end
        endcase
      end
    end else if (state == dnt_pkg::ST_SCAN) begin
      if (hit) begin
        if (func_q == dnt_pkg::FN_LOOKUP) begin
          res.found <= 1'b1;
          res.index <= 7'(idx);
        end
      end else if (idx == LAST_IDX) begin
        res.failed <= (func_q != dnt_pkg::FN_LOOKUP);
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slots[i] <= 8'd0;
      end
    end else if (load && (func_in == dnt_pkg::FN_CLEAR)) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slots[i] <= 8'd0;
      end
    end else if ((state == dnt_pkg::ST_SCAN) && hit && (func_q != dnt_pkg::FN_LOOKUP)) begin
      slots[idx] <= wval;
    end
  end

endmodule

@@ rtl/core/device_number_table.sv @@
// Device number table.
// Holds TABLE_SIZE slots of 8-bit device numbers; 0 marks a free slot.
// cmd channel (valid/ready): func and device. func selects add, remove,
// lookup, clear or restore of the default number. rsp channel (valid/ready):
// failed, found and index, exactly one transfer for every cmd transfer, in order.
// cfg_we/cfg_wdata write the default device number used by restore; write
// only while no command is in flight.
// Clear, unused codes and negative-code lookups go from idle straight to
// the done state. Add, remove, restore and table lookups walk the slots
// through one shared comparator, one slot per cycle, visiting 1 to
// TABLE_SIZE slots. One command at a time: cmd.ready is high only while
// the sequencer is idle.
// The rsp register frees the sequencer: a new command may be taken while
// the previous result still waits. If the receiver stalls longer, the next
// result holds in the sequencer and cmd.ready stays low.
// Reset (rst, synchronous) frees every slot, sets the default number to 8
// and empties the rsp register.
module device_number_table #(
  parameter int TABLE_SIZE = dnt_pkg::TABLE_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dnt_cmd_if.sink   cmd,
  dnt_rsp_if.source rsp,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]       default_device;
  logic             res_valid;
  logic             res_take;
  dnt_pkg::result_t res;
  logic             rsp_valid;
  dnt_pkg::result_t rsp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_device <= dnt_pkg::DEFAULT_DEVICE_RESET;
    end else if (cfg_we) begin
      default_device <= cfg_wdata;
    end
  end

  dnt_ctrl #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd.valid),
    .cmd_func       (cmd.func),
    .cmd_device     (cmd.device),
    .cmd_ready      (cmd.ready),
    .default_device (default_device),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res)
  );

  assign res_take = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid  = rsp_valid;
  assign rsp.failed = rsp_data.failed;
  assign rsp.found  = rsp_data.found;
  assign rsp.index  = rsp_data.index;

endmodule

@@ rtl/core/dnt_checker.sv @@
module dnt_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_failed,
  input logic       rsp_found,
  input logic [6:0] rsp_index
);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) && $stable(rsp_found)
      && $stable(rsp_failed))
    else $error("rsp changed while stalled");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd taken while a command is in flight");

  a_fail_xor_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_failed && rsp_found))
    else $error("failed and found both set");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_index == 7'd0)
    else $error("index set without found");

endmodule

bind device_number_table dnt_checker u_dnt_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_failed (rsp.failed),
  .rsp_found  (rsp.found),
  .rsp_index  (rsp.index)
);
